// ===== hw/rtl/crast_pkg.sv =====
`timescale 1ns / 1ps
// circle rasterizer package: payload structs, command struct, widths and constants
// no dependencies

package crast_pkg;

  localparam int COORD_BITS = 10;
  localparam int RADIUS_W   = 9;
  localparam int PIX_W      = 12;
  localparam int OCT_W      = RADIUS_W + 2;
  localparam int DEC_W      = 14;
  localparam int REFL_W     = 3;

  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(15);
  localparam logic [REFL_W-1:0]   REFL_LAST    = REFL_W'(7);
  localparam logic [REFL_W-1:0]   REFL_SWAP    = REFL_W'(4);
  localparam logic signed [DEC_W-1:0] D_INIT     = DEC_W'(3);
  localparam logic signed [DEC_W-1:0] D_DIAG     = DEC_W'(10);
  localparam logic signed [DEC_W-1:0] D_STRAIGHT = DEC_W'(6);

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } crast_kind_t;

  typedef struct packed {
    crast_kind_t            kind;
    logic [COORD_BITS-1:0]  center_x;
    logic [COORD_BITS-1:0]  center_y;
  } crast_in_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic                    last;
  } crast_res_t;

  typedef struct packed {
    crast_kind_t              kind;
    logic [COORD_BITS-1:0]    center_x;
    logic [COORD_BITS-1:0]    center_y;
    logic [RADIUS_W-1:0]      radius;
    logic signed [DEC_W-1:0]  d_init;
  } crast_cmd_t;

endpackage

// ===== hw/rtl/crast_front.sv =====
`timescale 1ns / 1ps
// front end: accepts items, tags every item with radius and initial decision, queues them
// depends on crast_pkg

module crast_front (
  input  logic                   clk,
  input  logic                   rst,
  input  crast_pkg::crast_in_t   command,
  input  logic                   push,
  output logic                   full,
  input  logic [crast_pkg::RADIUS_W-1:0] radius,
  output crast_pkg::crast_cmd_t  cmd,
  output logic                   cmd_valid,
  input  logic                   cmd_pop
);
  import crast_pkg::*;

  crast_cmd_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       wr_en;
  crast_cmd_t entry;

  assign full      = (count == 2'd2);
  assign cmd_valid = (count != 2'd0);
  assign wr_en     = push && !full;
  assign cmd       = mem[rd_ptr];

  always_comb begin
    entry.kind     = command.kind;
    entry.center_x = command.center_x;
    entry.center_y = command.center_y;
    entry.radius   = radius;
    entry.d_init   = D_INIT - signed'(DEC_W'({radius, 1'b0}));
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(wr_en) - 2'(cmd_pop);
    end
  end

endmodule

// ===== hw/rtl/crast_back.sv =====
`timescale 1ns / 1ps
// back end: octant point sequencer, one reflected pixel per step command while a circle is active
// depends on crast_pkg

module crast_back (
  input  logic                  clk,
  input  logic                  rst,
  input  crast_pkg::crast_cmd_t cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  logic                  res_full,
  output crast_pkg::crast_res_t res,
  output logic                  res_push
);
  import crast_pkg::*;

  logic                     busy;
  logic [COORD_BITS-1:0]    hold_cx;
  logic [COORD_BITS-1:0]    hold_cy;
  logic signed [OCT_W-1:0]  octant_x;
  logic signed [OCT_W-1:0]  octant_y;
  logic signed [DEC_W-1:0]  decision;
  logic [REFL_W-1:0]        reflection;
  logic                     final_point;

  logic                     fire;
  logic                     is_start;
  logic signed [OCT_W-1:0]  a;
  logic signed [OCT_W-1:0]  b;
  logic signed [PIX_W-1:0]  cx_w;
  logic signed [PIX_W-1:0]  cy_w;
  logic signed [PIX_W-1:0]  a_w;
  logic signed [PIX_W-1:0]  b_w;
  logic signed [OCT_W-1:0]  x_next;
  logic signed [OCT_W-1:0]  y_next;
  logic signed [DEC_W-1:0]  decision_next;
  logic                     go_diag;

  assign fire     = cmd_valid && !res_full;
  assign cmd_pop  = fire;
  assign is_start = (cmd.kind == KIND_START);
  assign res_push = fire && !is_start && busy;

  // reflection select
  always_comb begin
    if (reflection < REFL_SWAP) begin
      a = octant_x;
      b = octant_y;
    end else begin
      a = octant_y;
      b = octant_x;
    end
    cx_w = signed'(PIX_W'(hold_cx));
    cy_w = signed'(PIX_W'(hold_cy));
    a_w  = PIX_W'(a);
    b_w  = PIX_W'(b);
    res.pixel_x = reflection[0] ? cx_w - a_w : cx_w + a_w;
    res.pixel_y = reflection[1] ? cy_w - b_w : cy_w + b_w;
    res.last    = final_point && (reflection == REFL_LAST);
  end

  // point advance
  always_comb begin
    go_diag = (decision > 0);
    x_next  = octant_x + OCT_W'(1);
    y_next  = go_diag ? octant_y - OCT_W'(1) : octant_y;
    if (go_diag) begin
      decision_next = decision + (DEC_W'(x_next - y_next) <<< 2) + D_DIAG;
    end else begin
      decision_next = decision + (DEC_W'(x_next) <<< 2) + D_STRAIGHT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      hold_cx     <= '0;
      hold_cy     <= '0;
      octant_x    <= '0;
      octant_y    <= '0;
      decision    <= '0;
      reflection  <= '0;
      final_point <= 1'b0;
    end else if (fire) begin
      if (is_start) begin
        busy        <= 1'b1;
        hold_cx     <= cmd.center_x;
        hold_cy     <= cmd.center_y;
        octant_x    <= '0;
        octant_y    <= signed'(OCT_W'(cmd.radius));
        decision    <= cmd.d_init;
        reflection  <= '0;
        final_point <= 1'b0;
      end else if (busy) begin
        reflection <= reflection + REFL_W'(1);
        if (reflection == REFL_LAST) begin
          if (final_point) begin
            busy <= 1'b0;
          end else begin
            octant_x    <= x_next;
            octant_y    <= y_next;
            decision    <= decision_next;
            final_point <= (y_next < x_next);
          end
        end
      end
    end
  end

  a_idle_refl: assert property (@(posedge clk) disable iff (rst)
    !busy |-> (reflection == '0))
    else $error("reflection not cleared while idle");

  a_push_busy: assert property (@(posedge clk) disable iff (rst)
    res_push |-> busy && !res_full)
    else $error("pixel pushed while idle or queue full");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (res_push && res.last) |=> !busy)
    else $error("circle did not end after last pixel");

endmodule

// ===== hw/rtl/crast_res_q.sv =====
`timescale 1ns / 1ps
// result queue: two-entry buffer between the sequencer and the pixel consumer
// depends on crast_pkg

module crast_res_q (
  input  logic                  clk,
  input  logic                  rst,
  input  crast_pkg::crast_res_t res,
  input  logic                  res_push,
  output logic                  res_full,
  output crast_pkg::crast_res_t pixel,
  output logic                  empty,
  input  logic                  pop
);
  import crast_pkg::*;

  crast_res_t mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       rd_en;

  assign res_full = (count == 2'd2);
  assign empty    = (count == 2'd0);
  assign rd_en    = pop && !empty;
  assign pixel    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (res_push) begin
      mem[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (res_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(res_push) - 2'(rd_en);
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("result queue count overflow");

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    res_full |-> !res_push)
    else $error("push into full result queue");

endmodule

// ===== hw/rtl/circle_rasterizer.sv =====
`timescale 1ns / 1ps
// circle rasterizer top level: radius register, front queue, sequencer, result queue
// depends on crast_pkg, crast_front, crast_back, crast_res_q
//
// usage
//   command channel: push/full; kind start latches a centre and restarts the
//   circle with the current radius, kind step asks for the next pixel
//   pixel channel: empty/pop; pixel_x, pixel_y and last of the oldest pixel
//   radius: radius_we/radius_wdata, written while the block is idle
// timing
//   a step is registered in the command queue, its pixel in the result queue
//   one item per cycle while the result queue has room; the octant sequencer
//   advances one reflection per step, and its point update is combinational
//   starts and steps while idle are taken by the sequencer and give no pixel
// reset
//   synchronous; both queues empty, sequencer idle, radius 15
// stall
//   a held pixel leaves the sequencer running until the two-entry result
//   queue fills; then the two-entry command queue fills and full rises

module circle_rasterizer (
  input  logic                             clk,
  input  logic                             rst,
  input  crast_pkg::crast_in_t             command,
  input  logic                             push,
  output logic                             full,
  output crast_pkg::crast_res_t            pixel,
  output logic                             empty,
  input  logic                             pop,
  input  logic                             radius_we,
  input  logic [crast_pkg::RADIUS_W-1:0]   radius_wdata
);
  import crast_pkg::*;

  logic [RADIUS_W-1:0] radius;
  crast_cmd_t          cmd;
  logic                cmd_valid;
  logic                cmd_pop;
  crast_res_t          res;
  logic                res_push;
  logic                res_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (radius_we) begin
      radius <= radius_wdata;
    end
  end

  crast_front u_front (
    .clk       (clk),
    .rst       (rst),
    .command   (command),
    .push      (push),
    .full      (full),
    .radius    (radius),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  crast_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res       (res),
    .res_push  (res_push)
  );

  crast_res_q u_res_q (
    .clk      (clk),
    .rst      (rst),
    .res      (res),
    .res_push (res_push),
    .res_full (res_full),
    .pixel    (pixel),
    .empty    (empty),
    .pop      (pop)
  );

endmodule
